[hw/rtl/rth_pkg.sv]
// rth_pkg: shared constants and types for the rgb to hsl converter
// holds pixel, result and divider-cell payload types; no dependencies

package rth_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CHAIN_LEN = (FRAC_BITS > 16) ? FRAC_BITS : 16;
  localparam int HUE_SH    = CHAIN_LEN - FRAC_BITS;

  localparam int CH_W    = 8;
  localparam int HUE_W   = 16;
  localparam int SAT_W   = 16;
  localparam int LIT_W   = 9;
  localparam int SREM_W  = 8;
  localparam int HDIV_W  = 11;
  localparam int XPROD_W = 24;
  localparam int XEXT_W  = CHAIN_LEN + XPROD_W;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rth_pix_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [LIT_W-1:0] lightness;
  } rth_hsl_t;

  typedef struct packed {
    logic                 grey;
    logic [LIT_W-1:0]     lightness;
    logic [SREM_W-1:0]    s_rem;
    logic [SREM_W-1:0]    s_div;
    logic [CHAIN_LEN-1:0] s_bits;
    logic [CHAIN_LEN-1:0] s_quo;
    logic [HDIV_W-1:0]    h_rem;
    logic [HDIV_W-1:0]    h_div;
    logic [CHAIN_LEN-1:0] h_quo;
  } rth_cell_t;

endpackage

[hw/rtl/rth_pix_if.sv]
// rth_pix_if: valid/ready channel carrying one rgb pixel per beat
// depends on rth_pkg

interface rth_pix_if import rth_pkg::*; ();
  logic     valid;
  logic     ready;
  rth_pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rth_hsl_if.sv]
// rth_hsl_if: valid/ready channel carrying one hue/saturation/lightness beat
// depends on rth_pkg

interface rth_hsl_if import rth_pkg::*; ();
  logic     valid;
  logic     ready;
  rth_hsl_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rgb_to_hsl_convert.sv]
// rgb_to_hsl_convert: top level, rgb pixel in, hue/saturation/lightness out
// depends on rth_pkg, rth_pix_if, rth_hsl_if, rth_prep, rth_div_cell, rth_pack
//
//   channel   dir  beat
//   in_ch     in   red, green, blue (8 bits each)
//   out_ch    out  hue (16), saturation (16), lightness (9)
//
// one beat per cycle in and out while the output is not stalled; the pipeline is
// the prep register and a row of divider cells, one quotient bit per cell
// synchronous active-low reset empties the pipeline
// a stalled output beat freezes the whole row; in_ch.ready follows that stall

module rgb_to_hsl_convert import rth_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  rth_pix_if.sink   in_ch,
  rth_hsl_if.source out_ch
);

  logic      adv;
  logic      v      [CHAIN_LEN+1];
  rth_cell_t stage  [CHAIN_LEN+1];

  assign adv         = !v[CHAIN_LEN] || out_ch.ready;
  assign in_ch.ready = adv;

  rth_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_v   (in_ch.valid),
    .pix    (in_ch.data),
    .v_r    (v[0]),
    .cell_r (stage[0])
  );

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
    rth_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .v_in    (v[i]),
      .cell_in (stage[i]),
      .v_r     (v[i+1]),
      .cell_r  (stage[i+1])
    );
  end

  rth_pack u_pack (
    .cell_in (stage[CHAIN_LEN]),
    .res     (out_ch.data)
  );

  assign out_ch.valid = v[CHAIN_LEN];

endmodule

[hw/rtl/rth_prep.sv]
// rth_prep: front stage, finds max/min, lightness, sector position and divisors
// depends on rth_pkg; feeds the first divider cell

module rth_prep import rth_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_v,
  input  rth_pix_t  pix,
  output logic      v_r,
  output rth_cell_t cell_r
);

  logic [CH_W-1:0]    mx, mn, d;
  logic [LIT_W-1:0]   sum, den_w;
  logic [HDIV_W-1:0]  d6, n;
  logic [XPROD_W-1:0] xprod;
  logic [XEXT_W-1:0]  xext;
  rth_cell_t          cell_nxt;

  always_comb begin
    mx = (pix.red > pix.green) ? pix.red : pix.green;
    if (pix.blue > mx) mx = pix.blue;
    mn = (pix.red < pix.green) ? pix.red : pix.green;
    if (pix.blue < mn) mn = pix.blue;
    d     = mx - mn;
    sum   = LIT_W'(mx) + LIT_W'(mn);
    den_w = (sum <= LIT_W'(255)) ? sum : (LIT_W'(510) - sum);
    d6    = (HDIV_W'(d) << 2) + (HDIV_W'(d) << 1);
    if (mx == pix.red) begin
      if (pix.green >= pix.blue) n = HDIV_W'(pix.green) - HDIV_W'(pix.blue);
      else n = d6 - (HDIV_W'(pix.blue) - HDIV_W'(pix.green));
    end else if (mx == pix.green) begin
      n = (HDIV_W'(d) << 1) + HDIV_W'(pix.blue) - HDIV_W'(pix.red);
    end else begin
      n = (HDIV_W'(d) << 2) + HDIV_W'(pix.red) - HDIV_W'(pix.green);
    end
    // d * 65535 as a shift and subtract
    xprod = (XPROD_W'(d) << 16) - XPROD_W'(d);
    xext  = XEXT_W'(xprod);

    cell_nxt.grey      = (d == '0);
    cell_nxt.lightness = sum;
    cell_nxt.s_rem     = xext[CHAIN_LEN +: SREM_W];
    cell_nxt.s_div     = den_w[SREM_W-1:0];
    cell_nxt.s_bits    = xext[CHAIN_LEN-1:0];
    cell_nxt.s_quo     = '0;
    cell_nxt.h_rem     = n;
    cell_nxt.h_div     = d6;
    cell_nxt.h_quo     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r <= cell_nxt;
    end
  end

endmodule

[hw/rtl/rth_div_cell.sv]
// rth_div_cell: one restoring-division step for saturation and for hue
// depends on rth_pkg; chained, one quotient bit of each per cell

module rth_div_cell import rth_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      v_in,
  input  rth_cell_t cell_in,
  output logic      v_r,
  output rth_cell_t cell_r
);

  logic [SREM_W:0] s_try;
  logic [HDIV_W:0] h_try;
  logic            s_ge, h_ge;
  rth_cell_t       cell_nxt;

  always_comb begin
    s_try = {cell_in.s_rem, cell_in.s_bits[CHAIN_LEN-1]};
    h_try = {cell_in.h_rem, 1'b0};
    s_ge  = (s_try >= {1'b0, cell_in.s_div});
    h_ge  = (h_try >= {1'b0, cell_in.h_div});

    cell_nxt        = cell_in;
    cell_nxt.s_bits = cell_in.s_bits << 1;
    cell_nxt.s_rem  = s_ge ? SREM_W'(s_try - {1'b0, cell_in.s_div}) : s_try[SREM_W-1:0];
    cell_nxt.s_quo  = {cell_in.s_quo[CHAIN_LEN-2:0], s_ge};
    cell_nxt.h_rem  = h_ge ? HDIV_W'(h_try - {1'b0, cell_in.h_div}) : h_try[HDIV_W-1:0];
    cell_nxt.h_quo  = {cell_in.h_quo[CHAIN_LEN-2:0], h_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cell_r <= cell_nxt;
    end
  end

endmodule

[hw/rtl/rth_pack.sv]
// rth_pack: turns the last cell's quotients into the result beat
// depends on rth_pkg; scales and clamps hue, zeroes hue and saturation of grey pixels

module rth_pack import rth_pkg::*; (
  input  rth_cell_t cell_in,
  output rth_hsl_t  res
);

  logic [CHAIN_LEN-1:0] hv;

  always_comb begin
    hv = cell_in.h_quo >> HUE_SH;
    res.lightness = cell_in.lightness;
    if (cell_in.grey) begin
      res.hue        = '0;
      res.saturation = '0;
    end else begin
      res.hue        = (hv > CHAIN_LEN'(16'hFFFF)) ? 16'hFFFF : hv[HUE_W-1:0];
      res.saturation = cell_in.s_quo[SAT_W-1:0];
    end
  end

endmodule
